### hw/rtl/cksp_pkg.sv
package cksp_pkg;

    // Characters the parser looks for
    localparam logic [7:0] CH_SEMI  = 8'h3B;   // ';'
    localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;   // '1'
    localparam logic [7:0] CH_NINE  = 8'h39;   // '9'
    localparam logic [7:0] CH_EIGHT = 8'h38;   // '8'
    localparam logic [7:0] CH_U     = 8'h75;   // 'u'
    localparam logic [7:0] CH_TILDE = 8'h7E;   // '~'
    localparam int unsigned RADIX   = 10;

    localparam int unsigned KEY_W = 16;
    localparam int unsigned MOD_W = 4;

    // Result error codes, ranked low to high
    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_FINAL  = 3'd1,
        ERR_FIRST  = 3'd2,
        ERR_SEMI   = 3'd3,
        ERR_MOD    = 3'd4,
        ERR_DIGIT  = 3'd5,
        ERR_LETTER = 3'd6
    } t_err;

    // Per-sequence tracking, everything but the number accumulator
    typedef struct packed {
        logic [2:0] byte_count;   // body bytes so far, saturates at 7
        logic       semi_seen;
        logic [1:0] after_semi;   // bytes after first ';', saturates at 3
        logic [7:0] mod_digit;    // latest byte after first ';'
        logic       first_digit;
        logic       nondigit;
        logic       first_one;
    } t_seq_state;

    // One result beat
    typedef struct packed {
        logic [KEY_W-1:0] key_number;
        logic [MOD_W-1:0] modifier;
        logic [7:0]       final_byte;
        t_err             error_code;
    } t_result;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_mod(input logic [7:0] b);
        return (b >= CH_ONE) && (b <= CH_EIGHT);
    endfunction

    function automatic logic is_letter_final(input logic [7:0] b);
        return b inside {8'h41, 8'h42, 8'h43, 8'h44, 8'h46, 8'h48,
                         8'h50, 8'h51, 8'h52, 8'h53, 8'h5A};
    endfunction

endpackage

### hw/rtl/csi_key_sequence_parser_core.sv
// CSI key sequence parser.
// Input channel (i_valid / o_stall): one body byte of a terminal CSI key
// sequence per beat, ESC [ already stripped; i_is_last marks the final byte.
// Output channel (o_valid / i_stall): one result beat per sequence, issued
// for the beat flagged last: key number (saturating), modifier 1..8, final
// byte and an error code (0 means ok, key number and modifier are 0 on error).
// Path: a byte accepted lands in the input register; a last byte's result is
// then written into the output register, which drives o_valid.
// Throughput: one byte per cycle while o_stall is low; the digit multiply-add
// fits between the input register and the accumulator register, and the final
// checks between the input register and the output register.
// Stall: while the output register holds an untaken result and i_stall is
// high, a last byte waiting in the input register holds and o_stall goes
// high; bytes that are not last keep flowing.
// Reset: synchronous, active low; clears both valid flags and the parse state.
module csi_key_sequence_parser_core #(
    parameter int unsigned NUMBER_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_key_number,
    output logic [3:0]  o_modifier,
    output logic [7:0]  o_final_byte,
    output logic [2:0]  o_error_code
);
    import cksp_pkg::*;

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_last;
    logic                    r_out_valid;
    t_result                 r_out;
    logic                    out_free;
    logic                    s1_fire;
    logic [NUMBER_WIDTH-1:0] acc_number;
    t_seq_state              acc_state;
    t_result                 eval_result;

    // Handshake: only a last byte needs room in the output register
    assign out_free = !r_out_valid || !i_stall;
    assign s1_fire  = r_in_valid && (!r_in_last || out_free);
    assign o_stall  = r_in_valid && r_in_last && !out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_is_last;
        end
    end

    cksp_accum #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_last  (r_in_last),
        .i_byte  (r_in_byte),
        .o_number(acc_number),
        .o_state (acc_state)
    );

    cksp_eval #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_eval (
        .i_byte  (r_in_byte),
        .i_number(acc_number),
        .i_state (acc_state),
        .o_result(eval_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_fire && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_fire && r_in_last) begin
            r_out <= eval_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_key_number = r_out.key_number;
    assign o_modifier   = r_out.modifier;
    assign o_final_byte = r_out.final_byte;
    assign o_error_code = r_out.error_code;

    // A new result only comes from a last byte moving out of the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in_last))
        else $error("result without a last byte");

    // Errors carry no number and no modifier
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.error_code != ERR_NONE)) |->
            ((r_out.key_number == '0) && (r_out.modifier == '0)))
        else $error("error result with payload");

    // Good results have a modifier from 1 to 8
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.error_code == ERR_NONE)) |->
            ((r_out.modifier >= 4'd1) && (r_out.modifier <= 4'd8)))
        else $error("modifier out of range");

endmodule

### hw/rtl/cksp_accum.sv
module cksp_accum #(
    parameter int unsigned NUMBER_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic                    i_last,
    input  logic [7:0]              i_byte,
    output logic [NUMBER_WIDTH-1:0] o_number,
    output cksp_pkg::t_seq_state    o_state
);
    import cksp_pkg::*;

    localparam int unsigned PW = NUMBER_WIDTH + 4;

    logic [NUMBER_WIDTH-1:0] r_number, n_number;
    t_seq_state              r_state, n_state;
    logic [PW-1:0]           prod;

    // Multiply-add of the next decimal digit, saturated
    assign prod = PW'(r_number) * PW'(RADIX) + PW'(i_byte[3:0]);

    always_comb begin
        n_number = r_number;
        n_state  = r_state;
        if (i_fire && i_last) begin
            n_number = '0;
            n_state  = '0;
        end else if (i_fire) begin
            if (r_state.byte_count == 3'd0) begin
                n_state.first_digit = is_digit(i_byte);
                n_state.first_one   = (i_byte == CH_ONE);
            end
            if (r_state.byte_count != 3'd7) begin
                n_state.byte_count = r_state.byte_count + 3'd1;
            end
            if (r_state.semi_seen) begin
                if (r_state.after_semi != 2'd3) begin
                    n_state.after_semi = r_state.after_semi + 2'd1;
                end
                n_state.mod_digit = i_byte;
            end else if (i_byte == CH_SEMI) begin
                n_state.semi_seen = 1'b1;
            end else if (is_digit(i_byte)) begin
                if (prod[PW-1:NUMBER_WIDTH] != '0) begin
                    n_number = '1;
                end else begin
                    n_number = prod[NUMBER_WIDTH-1:0];
                end
            end else begin
                n_state.nondigit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number <= '0;
            r_state  <= '0;
        end else begin
            r_number <= n_number;
            r_state  <= n_state;
        end
    end

    assign o_number = r_number;
    assign o_state  = r_state;

endmodule

### hw/rtl/cksp_eval.sv
module cksp_eval #(
    parameter int unsigned NUMBER_WIDTH = 16
) (
    input  logic [7:0]              i_byte,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    input  cksp_pkg::t_seq_state    i_state,
    output cksp_pkg::t_result       o_result
);
    import cksp_pkg::*;

    localparam int unsigned EW = (NUMBER_WIDTH > KEY_W) ? NUMBER_WIDTH : KEY_W;

    logic          one_mod;
    logic          mod_good;
    logic [EW-1:0] num_ext;

    assign one_mod  = i_state.semi_seen && (i_state.after_semi == 2'd1);
    assign mod_good = is_mod(i_state.mod_digit);
    assign num_ext  = EW'(i_number);

    // Final byte checks, first failing check wins
    always_comb begin
        o_result            = '0;
        o_result.final_byte = i_byte;
        o_result.error_code = ERR_NONE;
        if ((i_byte == CH_U) || (i_byte == CH_TILDE)) begin
            if (!i_state.first_digit) begin
                o_result.error_code = ERR_FIRST;
            end else if ((i_byte == CH_TILDE) && !i_state.semi_seen) begin
                if (i_state.nondigit) begin
                    o_result.error_code = ERR_DIGIT;
                end else begin
                    o_result.key_number = num_ext[KEY_W-1:0];
                    o_result.modifier   = MOD_W'(1);
                end
            end else if (!one_mod) begin
                o_result.error_code = ERR_SEMI;
            end else if (!mod_good) begin
                o_result.error_code = ERR_MOD;
            end else if (i_state.nondigit) begin
                o_result.error_code = ERR_DIGIT;
            end else begin
                o_result.key_number = num_ext[KEY_W-1:0];
                o_result.modifier   = i_state.mod_digit[MOD_W-1:0];
            end
        end else if (is_letter_final(i_byte)) begin
            if (i_state.byte_count == 3'd0) begin
                o_result.key_number = KEY_W'(1);
                o_result.modifier   = MOD_W'(1);
            end else if ((i_state.byte_count == 3'd3) && i_state.first_one &&
                         one_mod && mod_good) begin
                o_result.key_number = KEY_W'(1);
                o_result.modifier   = i_state.mod_digit[MOD_W-1:0];
            end else begin
                o_result.error_code = ERR_LETTER;
            end
        end else begin
            o_result.error_code = ERR_FINAL;
        end
    end

endmodule
